// ===== rtl/wtt_pkg.sv =====
package wtt_pkg;

	localparam int TABLE_DEPTH = 16;

	typedef enum logic [2:0] {
		CMD_BEGIN    = 3'd0,
		CMD_SUBMIT   = 3'd1,
		CMD_COMPLETE = 3'd2,
		CMD_ABANDON  = 3'd3,
		CMD_QUERY    = 3'd4,
		CMD_CONTAINS = 3'd5,
		CMD_RESET    = 3'd6,
		CMD_BAD      = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_FALSE        = 3'd1,
		ST_INVALID      = 3'd2,
		ST_IDS_OUT      = 3'd3,
		ST_SESSIONS_OUT = 3'd4,
		ST_FULL         = 3'd5
	} status_t;

	// fields compared against a slot
	typedef struct packed {
		logic [63:0] id;
		logic [63:0] frame;
		logic [63:0] view;
		logic [63:0] generation;
		logic [31:0] scale;
		logic [7:0]  tag;
	} entry_t;

	// per-cell action for the update cycle
	typedef struct packed {
		logic write;
		logic submit;
		logic remove;
		logic clear;
	} cell_ctl_t;

	// what a cell reports back
	typedef struct packed {
		logic valid;
		logic submitted;
		logic full_match;
		logic id_match;
	} cell_stat_t;

endpackage

// ===== rtl/wtt_cell.sv =====
module wtt_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  wtt_pkg::entry_t     key,
	input  wtt_pkg::cell_ctl_t  ctl,
	output wtt_pkg::cell_stat_t stat
);

	logic            valid_q;
	logic            sub_q;
	wtt_pkg::entry_t ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sub_q   <= 1'b0;
		end else if (ctl.clear || ctl.remove) begin
			valid_q <= 1'b0;
			sub_q   <= 1'b0;
		end else if (ctl.write) begin
			valid_q <= 1'b1;
			sub_q   <= 1'b0;
		end else if (ctl.submit) begin
			sub_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.write) begin
			ent_q <= key;
		end
	end

	// registered compare, used by the decision step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat <= '0;
		end else begin
			stat.valid      <= valid_q;
			stat.submitted  <= sub_q;
			stat.id_match   <= valid_q && (ent_q.id == key.id);
			stat.full_match <= valid_q && (ent_q == key);
		end
	end

endmodule

// ===== rtl/work_ticket_tracker_unit.sv =====
// work ticket tracker: a row of table cells holding outstanding tickets
// input channel: in_valid/in_ready with cmd and the ticket fields, one
// command per transaction; output channel: out_valid/out_ready with
// status, issued_id and session_now, one result per transaction
// after acceptance, each cell first compares the staged command against
// its entry (registered match flags); then the block chooses the cell,
// updates it and loads the result register, which raises out_valid
// a new command is taken only once the staged one has been decided;
// so the next command is taken while a result still waits in the
// output register, and its compare runs, but it is not decided until
// that register frees
// reset: table empty, session zero, next id one, no result pending
// a stall on the output holds the result and, once a command is staged,
// holds in_ready low
module work_ticket_tracker_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [63:0] ticket_id,
	input  logic [63:0] ticket_session,
	input  logic [63:0] source_frame,
	input  logic [63:0] view_key,
	input  logic [63:0] config_generation,
	input  logic [31:0] scale_bits,
	input  logic [7:0]  precision_tag,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [63:0] issued_id,
	output logic [63:0] session_now
);

	localparam int D = wtt_pkg::TABLE_DEPTH;

	// staged command
	logic            have_q;
	logic            cmp_q;     // compare in flight
	logic            done_q;    // flags ready
	logic [2:0]      cmd_q;
	logic [63:0]     sess_in_q;
	wtt_pkg::entry_t key_q;
	wtt_pkg::entry_t key;

	logic [63:0] next_id_q;
	logic [63:0] session_q;

	wtt_pkg::cell_ctl_t  ctl  [D];
	wtt_pkg::cell_stat_t stat [D];

	// begin writes the fresh id into the slot
	always_comb begin
		key = key_q;
		if (cmd_q == wtt_pkg::CMD_BEGIN) begin
			key.id = next_id_q;
		end
	end

	for (genvar g = 0; g < D; g++) begin : g_cell
		wtt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.key    (key),
			.ctl    (ctl[g]),
			.stat   (stat[g])
		);
	end

	assign in_ready = !have_q;

	// decode
	logic            fire;
	logic            sess_ok;
	logic            scale_ok;
	logic [D-1:0]    hit;
	logic [D-1:0]    idhit;
	logic [D-1:0]    freev;
	logic [D-1:0]    sel;
	logic [D-1:0]    freesel;
	logic            any_hit;
	logic            hit_sub;
	logic            any_free;
	wtt_pkg::status_t st;
	logic [63:0]     issued;
	logic            do_write;
	logic            do_submit;
	logic            do_remove;
	logic            do_clear;

	assign fire = done_q && (!out_valid || out_ready);
	assign sess_ok = (sess_in_q == session_q) && (key_q.id != 64'd0);
	assign scale_ok = !key_q.scale[31] && (key_q.scale[30:23] != 8'hFF)
		&& (key_q.scale != 32'd0);

	always_comb begin
		for (int i = 0; i < D; i++) begin
			hit[i]   = stat[i].full_match && sess_ok;
			idhit[i] = stat[i].id_match;
			freev[i] = !stat[i].valid;
		end
		// lowest set bit
		sel     = hit & (~hit + 1'b1);
		freesel = freev & (~freev + 1'b1);
		any_hit  = |hit;
		any_free = |freev;
		hit_sub  = 1'b0;
		for (int i = 0; i < D; i++) begin
			hit_sub = hit_sub | (sel[i] & stat[i].submitted);
		end
	end

	always_comb begin
		st = wtt_pkg::ST_FALSE;
		issued = 64'd0;
		do_write = 1'b0;
		do_submit = 1'b0;
		do_remove = 1'b0;
		do_clear = 1'b0;
		case (cmd_q)
			wtt_pkg::CMD_BEGIN: begin
				if (key_q.frame == 64'd0 || !scale_ok) begin
					st = wtt_pkg::ST_INVALID;
				end else if (next_id_q == 64'd0) begin
					st = wtt_pkg::ST_IDS_OUT;
				end else if (!any_free) begin
					st = wtt_pkg::ST_FULL;
				end else begin
					st = wtt_pkg::ST_OK;
					issued = next_id_q;
					do_write = 1'b1;
				end
			end
			wtt_pkg::CMD_SUBMIT: begin
				if (any_hit && !hit_sub) begin
					st = wtt_pkg::ST_OK;
					do_submit = 1'b1;
				end
			end
			wtt_pkg::CMD_COMPLETE: begin
				if (any_hit && hit_sub) begin
					st = wtt_pkg::ST_OK;
					do_remove = 1'b1;
				end
			end
			wtt_pkg::CMD_ABANDON: begin
				if (any_hit) begin
					st = wtt_pkg::ST_OK;
					do_remove = 1'b1;
				end
			end
			wtt_pkg::CMD_QUERY: begin
				if (any_hit && hit_sub) begin
					st = wtt_pkg::ST_OK;
				end
			end
			wtt_pkg::CMD_CONTAINS: begin
				if (|idhit) begin
					st = wtt_pkg::ST_OK;
				end
			end
			wtt_pkg::CMD_RESET: begin
				if (session_q == '1) begin
					st = wtt_pkg::ST_SESSIONS_OUT;
				end else begin
					st = wtt_pkg::ST_OK;
					do_clear = 1'b1;
				end
			end
			default: begin
				st = wtt_pkg::ST_INVALID;
			end
		endcase
	end

	always_comb begin
		for (int i = 0; i < D; i++) begin
			ctl[i].write  = fire && do_write && freesel[i];
			ctl[i].submit = fire && do_submit && sel[i];
			ctl[i].remove = fire && do_remove && sel[i];
			ctl[i].clear  = fire && do_clear;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q     <= cmd;
			sess_in_q <= ticket_session;
			key_q     <= '{id: ticket_id, frame: source_frame, view: view_key,
				generation: config_generation, scale: scale_bits,
				tag: precision_tag};
		end
		if (fire) begin
			status      <= st;
			issued_id   <= issued;
			session_now <= do_clear ? session_q + 64'd1 : session_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q    <= 1'b0;
			cmp_q     <= 1'b0;
			done_q    <= 1'b0;
			out_valid <= 1'b0;
			next_id_q <= 64'd1;
			session_q <= 64'd0;
		end else begin
			if (in_valid && in_ready) begin
				have_q <= 1'b1;
				cmp_q  <= 1'b1;
			end
			if (cmp_q) begin
				cmp_q  <= 1'b0;
				done_q <= 1'b1;
			end
			if (fire) begin
				have_q <= 1'b0;
				done_q <= 1'b0;
				if (do_write) begin
					next_id_q <= next_id_q + 64'd1;
				end
				if (do_clear) begin
					session_q <= session_q + 64'd1;
				end
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_single_stage: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmp_q && done_q))
		else $error("compare and decide overlap");
	a_fire_needs_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> have_q)
		else $error("decision without a staged command");
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(freesel))
		else $error("free slot select not one-hot");
	a_session_step: assert property (@(posedge clk) disable iff (!arst_n)
		(session_q != $past(session_q)) |-> $past(fire && do_clear))
		else $error("session moved without a reset command");
`endif

endmodule
